// ----- rtl/core/scfl_pkg.sv -----
`default_nettype none
package scfl_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int POOL_PIECES = 1024;
	localparam int REG_CLASSES = 4;
	localparam int ACT_CLASSES = (NUM_CLASSES > REG_CLASSES) ? REG_CLASSES : NUM_CLASSES;

	localparam int POOL_AW    = $clog2(POOL_PIECES);
	localparam int LINK_W     = POOL_AW + 1;
	localparam int CLASS_W    = 2;
	localparam int SIZE_W     = 16;
	localparam int HANDLE_W   = 10;
	localparam int STATUS_W   = 2;
	localparam int GCNT_W     = 11;
	localparam int FACTOR_W   = 8;
	localparam int FRAC_BITS  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MEM_W      = CLASS_W + LINK_W;
	localparam int CMP_W      = (LINK_W > HANDLE_W) ? LINK_W : HANDLE_W;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [REG_CLASSES-1:0][SIZE_W-1:0] size_arr_t;

	typedef struct packed {
		logic [GCNT_W-1:0]   gmin;
		logic [GCNT_W-1:0]   gmax;
		logic [FACTOR_W-1:0] factor;
	} grow_cfg_t;

	localparam link_t NIL_LINK = link_t'(POOL_PIECES);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CLASS0_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_SIZE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS2_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS3_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACTOR = 3'd6;

endpackage
`default_nettype wire

// ----- rtl/core/scfl_ram.sv -----
`default_nettype none
module scfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/scfl_class_sel.sv -----
`default_nettype none
module scfl_class_sel (
	input  wire logic [scfl_pkg::SIZE_W-1:0]  req_size,
	input  wire scfl_pkg::size_arr_t          sizes,
	output logic                              fit,
	output logic      [scfl_pkg::CLASS_W-1:0] cls
);
	import scfl_pkg::*;

	// Walk downward so the lowest fitting index is the one left standing.
	always_comb begin
		fit = 1'b0;
		cls = '0;
		for (int c = ACT_CLASSES - 1; c >= 0; c--) begin
			if (req_size <= sizes[c]) begin
				fit = 1'b1;
				cls = CLASS_W'(c);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/scfl_grow.sv -----
`default_nettype none
module scfl_grow (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire scfl_pkg::link_t     total,
	input  wire scfl_pkg::grow_cfg_t cfg,
	input  wire scfl_pkg::link_t     carve,
	output scfl_pkg::link_t          n
);
	import scfl_pkg::*;

	localparam int PROD_W = LINK_W + FACTOR_W;
	localparam int NRAW_W = PROD_W - FRAC_BITS;

	logic [PROD_W-1:0] prod_q;
	logic [NRAW_W-1:0] nraw;
	logic [NRAW_W-1:0] gmin_x;
	logic [NRAW_W-1:0] gmax_x;
	logic [NRAW_W-1:0] left_x;
	logic [NRAW_W-1:0] n_clamp;
	link_t             left;

	// The product is registered; clamping runs in the following cycle.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_W'(total) * PROD_W'(cfg.factor);
		end
	end

	always_comb begin
		nraw   = prod_q[PROD_W-1:FRAC_BITS];
		gmin_x = NRAW_W'(cfg.gmin);
		gmax_x = NRAW_W'(cfg.gmax);
		left   = NIL_LINK - carve;
		left_x = NRAW_W'(left);
		if (nraw < gmin_x) begin
			n_clamp = gmin_x;
		end else if (nraw > gmax_x) begin
			n_clamp = gmax_x;
		end else begin
			n_clamp = nraw;
		end
		if (n_clamp > left_x) begin
			n_clamp = left_x;
		end
		n = LINK_W'(n_clamp);
	end

endmodule
`default_nettype wire

// ----- rtl/core/size_class_free_list_allocator.sv -----
`default_nettype none
// Free-list piece allocator with four size classes over one shared pool of handles. An
// item is taken when start is high and busy is low; its single result appears on the
// result ports for exactly one cycle with done high and cannot be held off. Requests that
// are rejected outright (no class fits, null or uncarved release) raise done in the cycle
// after they are taken. An allocate from a nonempty list and a release pass through ST_POP
// or ST_REL while the registered read of the link memory returns. An empty list is first
// refilled by carving n pieces, one link write per cycle, through ST_GMUL, ST_GCHK, ST_GROW
// and ST_PRD before ST_POP; with nothing left to carve, ST_GCHK gives the exhausted status.
// The link memory needs no clearing after reset: only carved handles are ever read.
module size_class_free_list_allocator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             op,
	input  wire logic [scfl_pkg::SIZE_W-1:0]      req_size,
	input  wire logic [scfl_pkg::HANDLE_W-1:0]    piece_handle,
	input  wire logic                             handle_present,
	output logic                                  done,
	output logic      [scfl_pkg::STATUS_W-1:0]    status,
	output logic      [scfl_pkg::HANDLE_W-1:0]    out_handle,
	output logic      [scfl_pkg::CLASS_W-1:0]     out_class,
	output logic      [scfl_pkg::SIZE_W-1:0]      out_size,
	input  wire logic                             cfg_wr_en,
	input  wire logic [scfl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [scfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import scfl_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GMUL = 3'd1;
	localparam logic [2:0] ST_GCHK = 3'd2;
	localparam logic [2:0] ST_GROW = 3'd3;
	localparam logic [2:0] ST_PRD  = 3'd4;
	localparam logic [2:0] ST_POP  = 3'd5;
	localparam logic [2:0] ST_REL  = 3'd6;

	logic [2:0]                 state_q;
	size_arr_t                  class_size_q;
	grow_cfg_t                  grow_cfg_q;
	link_t                      head_q [REG_CLASSES];
	link_t                      total_q [REG_CLASSES];
	link_t                      carve_q;
	logic [CLASS_W-1:0]         class_q;
	link_t                      n_q;
	link_t                      i_q;
	logic [POOL_AW-1:0]         rel_q;

	logic                       done_q;
	logic [STATUS_W-1:0]        status_q;
	logic [HANDLE_W-1:0]        handle_q;
	logic [CLASS_W-1:0]         out_class_q;
	logic [SIZE_W-1:0]          out_size_q;

	logic                       sel_fit;
	logic [CLASS_W-1:0]         sel_cls;
	logic                       rel_ok;
	logic                       grow_load;
	link_t                      grow_n;
	link_t                      grow_addr;
	logic                       grow_last;

	logic                       ram_we;
	logic [POOL_AW-1:0]         ram_waddr;
	logic [MEM_W-1:0]           ram_wdata;
	logic                       ram_re;
	logic [POOL_AW-1:0]         ram_raddr;
	logic [MEM_W-1:0]           ram_rdata;
	logic [CLASS_W-1:0]         rel_tag;
	link_t                      rd_link;

	scfl_class_sel u_class_sel (
		.req_size (req_size),
		.sizes    (class_size_q),
		.fit      (sel_fit),
		.cls      (sel_cls)
	);

	scfl_grow u_grow (
		.clk   (clk),
		.load  (grow_load),
		.total (total_q[class_q]),
		.cfg   (grow_cfg_q),
		.carve (carve_q),
		.n     (grow_n)
	);

	// Each entry holds the class tag above the next link of its free list.
	scfl_ram #(
		.WIDTH (MEM_W),
		.DEPTH (POOL_PIECES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rel_tag   = ram_rdata[MEM_W-1:LINK_W];
	assign rd_link   = ram_rdata[LINK_W-1:0];
	assign rel_ok    = handle_present && (CMP_W'(piece_handle) < CMP_W'(carve_q));
	assign grow_addr = carve_q + i_q;
	assign grow_last = ((i_q + link_t'(1)) == n_q);
	assign busy      = (state_q != ST_IDLE);

	assign done       = done_q;
	assign status     = status_q;
	assign out_handle = handle_q;
	assign out_class  = out_class_q;
	assign out_size   = out_size_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		grow_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_RELEASE) begin
						ram_re    = rel_ok;
						ram_raddr = POOL_AW'(piece_handle);
					end else if (sel_fit && head_q[sel_cls] != NIL_LINK) begin
						ram_re    = 1'b1;
						ram_raddr = POOL_AW'(head_q[sel_cls]);
					end
				end
			end
			ST_GMUL: begin
				grow_load = 1'b1;
			end
			ST_GROW: begin
				// The last carved piece links to whatever the list held before.
				ram_we    = 1'b1;
				ram_waddr = POOL_AW'(grow_addr);
				ram_wdata = {class_q, grow_last ? head_q[class_q] : grow_addr + link_t'(1)};
			end
			ST_PRD: begin
				ram_re    = 1'b1;
				ram_raddr = POOL_AW'(head_q[class_q]);
			end
			ST_REL: begin
				ram_we    = 1'b1;
				ram_waddr = rel_q;
				ram_wdata = {rel_tag, head_q[rel_tag]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			class_size_q <= {SIZE_W'(1024), SIZE_W'(256), SIZE_W'(64), SIZE_W'(16)};
			grow_cfg_q   <= '{gmin: GCNT_W'(8), gmax: GCNT_W'(128), factor: FACTOR_W'(16)};
			for (int c = 0; c < REG_CLASSES; c++) begin
				head_q[c]  <= NIL_LINK;
				total_q[c] <= '0;
			end
			carve_q     <= '0;
			class_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			rel_q       <= '0;
			done_q      <= 1'b0;
			status_q    <= STATUS_OK;
			handle_q    <= '0;
			out_class_q <= '0;
			out_size_q  <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CLASS0_SIZE: class_size_q[0] <= cfg_data[SIZE_W-1:0];
					CFG_CLASS1_SIZE: class_size_q[1] <= cfg_data[SIZE_W-1:0];
					CFG_CLASS2_SIZE: class_size_q[2] <= cfg_data[SIZE_W-1:0];
					CFG_CLASS3_SIZE: class_size_q[3] <= cfg_data[SIZE_W-1:0];
					CFG_GROW_MIN:    grow_cfg_q.gmin <= cfg_data[GCNT_W-1:0];
					CFG_GROW_MAX:    grow_cfg_q.gmax <= cfg_data[GCNT_W-1:0];
					CFG_GROW_FACTOR: grow_cfg_q.factor <= cfg_data[FACTOR_W-1:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (op == OP_RELEASE) begin
							if (rel_ok) begin
								rel_q   <= POOL_AW'(piece_handle);
								state_q <= ST_REL;
							end else begin
								done_q      <= 1'b1;
								status_q    <= STATUS_IGNORED;
								handle_q    <= '0;
								out_class_q <= '0;
								out_size_q  <= '0;
							end
						end else if (!sel_fit) begin
							done_q      <= 1'b1;
							status_q    <= STATUS_NO_FIT;
							handle_q    <= '0;
							out_class_q <= '0;
							out_size_q  <= '0;
						end else begin
							class_q <= sel_cls;
							state_q <= (head_q[sel_cls] != NIL_LINK) ? ST_POP : ST_GMUL;
						end
					end
				end
				ST_GMUL: begin
					state_q <= ST_GCHK;
				end
				ST_GCHK: begin
					if (grow_n == '0) begin
						done_q      <= 1'b1;
						status_q    <= STATUS_EXHAUSTED;
						handle_q    <= '0;
						out_class_q <= '0;
						out_size_q  <= '0;
						state_q     <= ST_IDLE;
					end else begin
						n_q     <= grow_n;
						i_q     <= '0;
						state_q <= ST_GROW;
					end
				end
				ST_GROW: begin
					if (grow_last) begin
						head_q[class_q]  <= carve_q;
						total_q[class_q] <= total_q[class_q] + n_q;
						carve_q          <= carve_q + n_q;
						state_q          <= ST_PRD;
					end else begin
						i_q <= i_q + link_t'(1);
					end
				end
				ST_PRD: begin
					state_q <= ST_POP;
				end
				ST_POP: begin
					head_q[class_q] <= rd_link;
					done_q          <= 1'b1;
					status_q        <= STATUS_OK;
					handle_q        <= HANDLE_W'(head_q[class_q]);
					out_class_q     <= class_q;
					out_size_q      <= class_size_q[class_q];
					state_q         <= ST_IDLE;
				end
				ST_REL: begin
					head_q[rel_tag] <= link_t'(rel_q);
					done_q          <= 1'b1;
					status_q        <= STATUS_OK;
					handle_q        <= '0;
					out_class_q     <= '0;
					out_size_q      <= '0;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
